/* sv/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tpd_pkg.sv */
package tpd_pkg;

  localparam int TAG_W      = 56;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int SRC_W      = 8;
  localparam int DEB_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 88;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_READER = 2'd2;

  // request kinds
  localparam logic REQ_SCAN  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // event kinds
  localparam logic EV_REMOVED = 1'b0;
  localparam logic EV_SEEN    = 1'b1;

  localparam logic [SRC_W-1:0] SRC_ANY = '0;

  typedef struct packed {
    logic              req_type;
    logic              tag_present;
    logic [TAG_W-1:0]  tag_id;
    logic [SRC_W-1:0]  source_reader;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic             event_kind;
    logic [TAG_W-1:0] event_tag;
    logic [CNT_W-1:0] seen_total;
    logic             last_of_run;
  } res_t;

  // up to two results from one item; v1 only with v0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

/* sv/tpd_core.sv */
module tpd_core #(
  parameter int TAG_ID_BITS = 56
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  tpd_pkg::in_item_t                item,
  input  logic                             room,
  output tpd_pkg::push_t                   push
);
  import tpd_pkg::*;

  // stored tag width: the id field never carries more than TAG_W bits
  localparam int TW = (TAG_ID_BITS < TAG_W) ? TAG_ID_BITS : TAG_W;

  logic              enable_r;
  logic [DEB_W-1:0]  debounce_r;
  logic [SRC_W-1:0]  own_r;

  logic              in_valid_r, in_valid_nxt;
  in_item_t          in_r;

  logic              sp_r, sp_nxt;
  logic [TW-1:0]     st_r, st_nxt;
  logic              pv_r, pv_nxt;
  logic              pp_r, pp_nxt;
  logic [TW-1:0]     ptag_r, ptag_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              fire;
  logic [TW-1:0]     obs_tag;
  logic              same_stable;
  logic              same_pending;
  logic              src_ok;
  logic [TIME_W-1:0] elapsed;
  logic              do_commit;
  logic [CNT_W-1:0]  cnt_inc;

  assign fire       = in_valid_r && room;
  assign item_ready = !in_valid_r || room;

  assign obs_tag      = in_r.tag_present ? in_r.tag_id[TW-1:0] : '0;
  assign same_stable  = (sp_r == in_r.tag_present) && (!sp_r || st_r == obs_tag);
  assign same_pending = (pp_r == in_r.tag_present) && (!pp_r || ptag_r == obs_tag);
  assign src_ok       = (in_r.source_reader == SRC_ANY) || (in_r.source_reader == own_r);
  assign elapsed      = in_r.time_ms - since_r;
  assign cnt_inc      = cnt_r + CNT_W'(1);

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (item_valid && item_ready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    sp_nxt    = sp_r;
    st_nxt    = st_r;
    pv_nxt    = pv_r;
    pp_nxt    = pp_r;
    ptag_nxt  = ptag_r;
    since_nxt = since_r;
    cnt_nxt   = cnt_r;
    push      = '0;
    do_commit = 1'b0;
    if (fire) begin
      if (in_r.req_type == REQ_CLEAR) begin
        push.v0   = sp_r;
        push.r0   = '{event_kind: EV_REMOVED, event_tag: TAG_W'(st_r),
                      seen_total: cnt_r, last_of_run: 1'b1};
        sp_nxt    = 1'b0;
        st_nxt    = '0;
        pv_nxt    = 1'b0;
        pp_nxt    = 1'b0;
        ptag_nxt  = '0;
        since_nxt = '0;
        cnt_nxt   = '0;
      end else if (enable_r && src_ok) begin
        if (same_stable) begin
          pv_nxt   = 1'b0;
          pp_nxt   = 1'b0;
          ptag_nxt = '0;
        end else if (debounce_r == '0) begin
          do_commit = 1'b1;
        end else if (!pv_r || !same_pending) begin
          pv_nxt    = 1'b1;
          pp_nxt    = in_r.tag_present;
          ptag_nxt  = obs_tag;
          since_nxt = in_r.time_ms;
        end else if (elapsed >= TIME_W'(debounce_r)) begin
          do_commit = 1'b1;
        end
      end
    end
    // the pending candidate (or, with debounce zero, nothing pending) matches the report, so commit the report itself
    if (do_commit) begin
      pv_nxt   = 1'b0;
      pp_nxt   = 1'b0;
      ptag_nxt = '0;
      sp_nxt   = in_r.tag_present;
      st_nxt   = obs_tag;
      cnt_nxt  = in_r.tag_present ? cnt_inc : '0;
      if (sp_r) begin
        push.v0 = 1'b1;
        push.r0 = '{event_kind: EV_REMOVED, event_tag: TAG_W'(st_r),
                    seen_total: cnt_r, last_of_run: !in_r.tag_present};
        if (in_r.tag_present) begin
          push.v1 = 1'b1;
          push.r1 = '{event_kind: EV_SEEN, event_tag: TAG_W'(obs_tag),
                      seen_total: cnt_inc, last_of_run: 1'b1};
        end
      end else begin
        push.v0 = in_r.tag_present;
        push.r0 = '{event_kind: EV_SEEN, event_tag: TAG_W'(obs_tag),
                    seen_total: cnt_inc, last_of_run: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      debounce_r <= '0;
      own_r      <= SRC_W'(1);
      in_valid_r <= 1'b0;
      sp_r       <= 1'b0;
      st_r       <= '0;
      pv_r       <= 1'b0;
      pp_r       <= 1'b0;
      ptag_r     <= '0;
      since_r    <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENABLE:     enable_r   <= cfg_wdata[0];
          REG_DEBOUNCE:   debounce_r <= cfg_wdata[DEB_W-1:0];
          REG_OWN_READER: own_r      <= cfg_wdata[SRC_W-1:0];
          default: ;
        endcase
      end
      in_valid_r <= in_valid_nxt;
      sp_r       <= sp_nxt;
      st_r       <= st_nxt;
      pv_r       <= pv_nxt;
      pp_r       <= pp_nxt;
      ptag_r     <= ptag_nxt;
      since_r    <= since_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_r <= item;
    end
  end

endmodule

/* sv/tpd_outq.sv */
module tpd_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  tpd_pkg::push_t push,
  output logic           room,
  output logic           head_valid,
  input  logic           head_ready,
  output tpd_pkg::res_t  head
);
  import tpd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr_p1;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  // two free entries so any item can be taken
  assign room       = (cnt_r <= (PW+1)'(DEPTH - 2));
  assign wr_ptr_p1  = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.v0) + PW'(push.v1);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + (PW+1)'(push.v0) + (PW+1)'(push.v1) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

/* sv/tag_presence_debouncer.sv */
// channel | dir | handshake               | payload
// in_     | in  | in_tvalid / in_tready   | tuser: req_type; tdata: report fields
// out_    | out | out_tvalid / out_tready | tuser: event_kind; tlast: last_of_run
// cfg_    | in  | cfg_we, no wait         | cfg_addr picks the register
//
// one report per cycle while the queue has room: a transfer lands in the input register,
// is compared and folded into the tag state once the queue has room, and its zero to two events go
// into a four-entry result queue whose head drives the out_ port
// a report waits in the input register while fewer than two queue slots are free,
// so a stalled out_ side backs up into in_tready once three or four events are
// queued and a report waits behind them
// reset (rst_n low, synchronous) clears tag state, counter, queue, enable and debounce; own reader resets to 1
module tag_presence_debouncer #(
  parameter int TAG_ID_BITS = 56
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [tpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // reports
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tag_present[0], tag_id[56:1], source_reader[64:57], time_ms[96:65], zero pad
  input  logic [tpd_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type
  input  logic                             in_tuser,
  // events
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // event_tag[55:0], seen_total[87:56]
  output logic [tpd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // event_kind
  output logic                             out_tuser,
  // last_of_run
  output logic                             out_tlast
);
  import tpd_pkg::*;

  in_item_t item;
  push_t    push;
  logic     room;
  res_t     head;

  // unpack the report bus
  assign item.req_type      = in_tuser;
  assign item.tag_present   = in_tdata[0];
  assign item.tag_id        = in_tdata[TAG_W:1];
  assign item.source_reader = in_tdata[TAG_W+SRC_W:TAG_W+1];
  assign item.time_ms       = in_tdata[TAG_W+SRC_W+TIME_W:TAG_W+SRC_W+1];

  // compare and update against stable and pending observations
  tpd_core #(
    .TAG_ID_BITS (TAG_ID_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .room       (room),
    .push       (push)
  );

  // removed/seen pairs drain one per transfer
  tpd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {head.seen_total, head.event_tag};
  assign out_tuser = head.event_kind;
  assign out_tlast = head.last_of_run;

endmodule

/* sv/tpd_checker.sv */
`include "assert_macros.svh"

module tpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tpd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tlast
);
  import tpd_pkg::*;

  // stalled event holds its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled event changed")

  // a seen event always closes its run
  `ASSERT_IMP(a_seen_last, clk, rst_n, out_tvalid && out_tuser == EV_SEEN, out_tlast, "seen event not last")

  // a removed event that is not last is followed at once by its seen event
  `ASSERT_NEXT(a_pair, clk, rst_n, out_tvalid && out_tready && out_tuser == EV_REMOVED && !out_tlast, out_tvalid && out_tuser == EV_SEEN, "removed without following seen")

  // nothing is offered right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid, "event offered after reset")

endmodule

bind tag_presence_debouncer tpd_checker u_tpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
